>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/bls_pkg.sv
package bls_pkg;

   // Coordinate and grid sizing.
   localparam int COORD_BITS = 12;
   localparam int GRID_BITS  = 11;
   localparam int ERR_BITS   = COORD_BITS + 2;

   // Command queue sizing; the depth is a power of two so pointers wrap freely.
   localparam int FIFO_DEPTH     = 2;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_COLS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GRID_ROWS = 1'd1;

   localparam logic [GRID_BITS-1:0] GRID_COLS_RESET = 11'd320;
   localparam logic [GRID_BITS-1:0] GRID_ROWS_RESET = 11'd200;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;

   typedef enum logic {
      KIND_START   = 1'b0,
      KIND_ADVANCE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      inside_res;
      logic      last;
   } rsp_type;

   // Classified command as it travels through the queue.
   typedef struct packed {
      kind_type  kind;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      delta_type delta_x;
      delta_type delta_y;
      logic      dir_x_neg;
      logic      dir_y_neg;
      err_type   err_init;
   } cmd_type;

   typedef struct packed {
      logic [GRID_BITS-1:0] cols;
      logic [GRID_BITS-1:0] rows;
   } grid_cfg_type;

endpackage

>>> hdl/bls_front.sv
module bls_front
   import bls_pkg::*;
(
   input  req_type req_data,
   output cmd_type cmd_data
);

   logic signed [COORD_BITS:0] diff_x;
   logic signed [COORD_BITS:0] diff_y;
   logic signed [COORD_BITS:0] abs_x;
   logic signed [COORD_BITS:0] abs_y;

   // Signed differences with one guard bit, so they never overflow.
   assign diff_x = $signed({req_data.end_x[COORD_BITS-1], req_data.end_x})
                 - $signed({req_data.start_x[COORD_BITS-1], req_data.start_x});
   assign diff_y = $signed({req_data.end_y[COORD_BITS-1], req_data.end_y})
                 - $signed({req_data.start_y[COORD_BITS-1], req_data.start_y});

   assign abs_x = diff_x[COORD_BITS] ? -diff_x : diff_x;
   assign abs_y = diff_y[COORD_BITS] ? -diff_y : diff_y;

   // Line setup: deltas, step directions and the starting error term.
   always_comb begin
      cmd_data.kind      = req_data.kind;
      cmd_data.start_x   = req_data.start_x;
      cmd_data.start_y   = req_data.start_y;
      cmd_data.end_x     = req_data.end_x;
      cmd_data.end_y     = req_data.end_y;
      cmd_data.delta_x   = abs_x[COORD_BITS-1:0];
      cmd_data.delta_y   = abs_y[COORD_BITS-1:0];
      cmd_data.dir_x_neg = !(diff_x > 0);
      cmd_data.dir_y_neg = !(diff_y > 0);
      cmd_data.err_init  = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, abs_x[COORD_BITS-1:0]})
                         - $signed({{(ERR_BITS-COORD_BITS){1'b0}}, abs_y[COORD_BITS-1:0]});
   end

endmodule

>>> hdl/bls_fifo.sv
module bls_fifo
   import bls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type                  mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     push;
   logic                     pop;

   assign push_ready = (count_ff != FIFO_CNT_BITS'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? FIFO_PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? FIFO_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = FIFO_CNT_BITS'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = FIFO_CNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/bls_back.sv
module bls_back
   import bls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  grid_cfg_type grid_cfg,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  cmd_type      cmd_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   output logic         busy
);

   localparam int CMP_BITS = (COORD_BITS > GRID_BITS) ? COORD_BITS : GRID_BITS;

   coord_type cur_x_ff, cur_x_in;
   coord_type cur_y_ff, cur_y_in;
   coord_type target_x_ff, target_x_in;
   coord_type target_y_ff, target_y_in;
   delta_type delta_x_ff, delta_x_in;
   delta_type delta_y_ff, delta_y_in;
   err_type   err_ff, err_in;
   logic      dir_x_neg_ff, dir_x_neg_in;
   logic      dir_y_neg_ff, dir_y_neg_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic                    take;
   logic                    emit;
   logic                    is_start;
   logic signed [ERR_BITS:0] e2;
   logic signed [ERR_BITS:0] dx_wide;
   logic signed [ERR_BITS:0] dy_wide;
   err_type                 dx_err;
   err_type                 dy_err;
   logic                    step_x;
   logic                    step_y;
   coord_type               inc_x;
   coord_type               inc_y;
   logic                    fin;
   logic                    in_x;
   logic                    in_y;

   // The output register frees up when empty or when its point is transferred.
   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign is_start  = (cmd_data.kind == KIND_START);
   assign emit      = take && (is_start || busy_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign busy      = busy_ff;

   // One Bresenham step: doubled error compared against both deltas.
   assign e2      = $signed({err_ff, 1'b0});
   assign dx_wide = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, delta_x_ff});
   assign dy_wide = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, delta_y_ff});
   assign dx_err  = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_x_ff});
   assign dy_err  = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, delta_y_ff});
   assign step_x  = (e2 > -dy_wide);
   assign step_y  = (e2 < dx_wide);
   assign inc_x   = dir_x_neg_ff ? '1 : COORD_BITS'(1);
   assign inc_y   = dir_y_neg_ff ? '1 : COORD_BITS'(1);

   // Next line state: load on a start, step on an advance while busy.
   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      delta_x_in   = delta_x_ff;
      delta_y_in   = delta_y_ff;
      err_in       = err_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      if (take && is_start) begin
         cur_x_in     = cmd_data.start_x;
         cur_y_in     = cmd_data.start_y;
         target_x_in  = cmd_data.end_x;
         target_y_in  = cmd_data.end_y;
         delta_x_in   = cmd_data.delta_x;
         delta_y_in   = cmd_data.delta_y;
         err_in       = cmd_data.err_init;
         dir_x_neg_in = cmd_data.dir_x_neg;
         dir_y_neg_in = cmd_data.dir_y_neg;
      end else if (emit) begin
         cur_x_in = step_x ? coord_type'(cur_x_ff + inc_x) : cur_x_ff;
         cur_y_in = step_y ? coord_type'(cur_y_ff + inc_y) : cur_y_ff;
         err_in   = err_type'(err_ff - (step_x ? dy_err : '0) + (step_y ? dx_err : '0));
      end
   end

   // Flags of the point being emitted, taken from the updated position.
   always_comb begin
      fin  = (cur_x_in == target_x_in) && (cur_y_in == target_y_in);
      in_x = !cur_x_in[COORD_BITS-1]
          && (CMP_BITS'($unsigned(cur_x_in)) < CMP_BITS'(grid_cfg.cols));
      in_y = !cur_y_in[COORD_BITS-1]
          && (CMP_BITS'($unsigned(cur_y_in)) < CMP_BITS'(grid_cfg.rows));
      rsp_data_in.point_x    = cur_x_in;
      rsp_data_in.point_y    = cur_y_in;
      rsp_data_in.inside_res = in_x && in_y;
      rsp_data_in.last       = fin;
   end

   // Busy and output valid control.
   always_comb begin
      busy_in      = emit ? !fin : busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Line state and output payload; only read once a start has loaded them.
   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      target_x_ff  <= target_x_in;
      target_y_ff  <= target_y_in;
      delta_x_ff   <= delta_x_in;
      delta_y_ff   <= delta_y_in;
      err_ff       <= err_in;
      dir_x_neg_ff <= dir_x_neg_in;
      dir_y_neg_ff <= dir_y_neg_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> hdl/bresenham_line_stepper.sv
// With the queue empty and the result channel free, a request is registered in the queue,
// then taken by the stepper into the output register, where its point shows on rsp_valid.
// Throughput: one item per cycle while rsp_ready accepts points, set by the error update in the stepper.
// An advance while no line is active is consumed and gives no point.
// Reset (synchronous, active high) empties the queue, makes the stepper idle and
// sets the grid to 320 columns by 200 rows.
`include "assert_macros.svh"

module bresenham_line_stepper
   import bls_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [GRID_BITS-1:0]      csr_wdata
);

   grid_cfg_type grid_ff, grid_in;
   cmd_type      front_cmd;
   cmd_type      queue_cmd;
   logic         queue_valid;
   logic         queue_ready;
   logic         start_on_idle;
   logic         back_busy;

   // Configuration registers.
   always_comb begin
      grid_in = grid_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GRID_COLS: grid_in.cols = csr_wdata;
            REG_GRID_ROWS: grid_in.rows = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff.cols <= GRID_COLS_RESET;
         grid_ff.rows <= GRID_ROWS_RESET;
      end else begin
         grid_ff <= grid_in;
      end
   end

   // Front end: line setup for each request.
   bls_front u_front (
      .req_data (req_data),
      .cmd_data (front_cmd)
   );

   // Queue between setup and stepping.
   bls_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   // A start transfer that meets an empty queue and a free output register.
   assign start_on_idle = req_valid && req_ready && (req_data.kind == KIND_START)
                       && !queue_valid && (!rsp_valid || rsp_ready);

   // Back end: stepping and the output register.
   bls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grid_cfg  (grid_ff),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd_data  (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .busy      (back_busy)
   );

   // No point is pending right after a reset cycle.
   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)
   // A pending point is flagged last exactly when the stepper has gone idle.
   `ASSERT_CLK(a_last_matches_busy, clock, reset, rsp_valid |-> (back_busy == !rsp_data.last))
   // A start that meets an empty queue and a free output passes through the queue and the output register, then emits.
   `ASSERT_CLK(a_start_emits, clock, reset, start_on_idle |-> ##2 rsp_valid)

endmodule
